@@ rtl/core/fwu_pkg.sv @@
// ----------------------------------------------------------------------------
// fwu_pkg
// Shared types and constants for the fiber word unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package fwu_pkg;

	localparam int FIBER_COUNT = 4;

	// word types, bits 31..28
	localparam logic [3:0] WT_TRIG_TIME = 4'h2;
	localparam logic [3:0] WT_LEADING   = 4'h4;
	localparam logic [3:0] WT_TRAILING  = 4'h5;
	localparam logic [3:0] WT_TRIG_FLAG = 4'hA;
	localparam logic [3:0] WT_GEO       = 4'hC;
	localparam logic [3:0] WT_HEADER    = 4'hD;
	localparam logic [3:0] WT_SEPARATOR = 4'hE;

	localparam logic [6:0] TRAY_MIN = 7'd1;
	localparam logic [6:0] TRAY_MAX = 7'd124;

	localparam logic [6:0] TRAY_SPECIAL_A = 7'd8;
	localparam logic [6:0] TRAY_SPECIAL_B = 7'd23;
	localparam logic [6:0] TRAY_SPECIAL_C = 7'd93;
	localparam logic [6:0] TRAY_SPECIAL_D = 7'd108;
	localparam logic [6:0] REMAP_YEAR     = 7'd13;

	localparam logic [7:0] CH_PER_TDIG    = 8'd24;
	localparam logic [7:0] CH_PER_HALF    = 8'd96;
	localparam logic [7:0] CH_MAX         = 8'd199;

	localparam logic [1:0] TDIG_LOWER_ANOM = 2'd1;
	localparam logic [1:0] TDIG_UPPER_ANOM = 2'd3;

	// register map: index is paddr[2]
	localparam int         PADDR_W      = 3;
	localparam logic [0:0] REG_RUN_YEAR = 1'b0;

	typedef enum logic [1:0] {
		KIND_LEADING  = 2'd0,
		KIND_TRAILING = 2'd1,
		KIND_TRIGGER  = 2'd2,
		KIND_BAD_TRAY = 2'd3
	} fwu_kind_t;

	typedef logic [FIBER_COUNT-1:0] fwu_trig_vec_t;

	typedef struct packed {
		logic       geo_seen;
		logic       half_tray;
		logic [6:0] tray;
	} fwu_state_t;

	typedef struct packed {
		fwu_kind_t   kind;
		logic [1:0]  fiber;
		logic [6:0]  tray;
		logic [7:0]  channel;
		logic [20:0] tdc_time;
		logic [31:0] raw;
		logic        anomaly;
	} fwu_result_t;

endpackage

`default_nettype wire

@@ rtl/core/tof_fiber_word_unpacker_top.sv @@
// A word accepted into the input register is decoded there; its result reaches the outputs from the result register.
// Throughput: one word per cycle; the input register moves on every cycle unless a
// result is held back by out_ready low while the output register is full.
// Reset (arst_n low, asynchronous): geography, tray, trigger capture and run_year
// clear to zero, both stages empty.
// ----------------------------------------------------------------------------
// tof_fiber_word_unpacker_top
// Fibre word unpacker: input register, decode, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_fiber_word_unpacker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fwu_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [31:0]                 data_word,
	input  logic [1:0]                  fiber_index,
	input  logic                        first_of_fiber,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  result_kind,
	output logic [1:0]                  fiber_out,
	output logic [6:0]                  tray_number,
	output logic [7:0]                  channel_number,
	output logic [20:0]                 tdc_time,
	output logic [31:0]                 raw_word,
	output logic                        channel_anomaly
);
	import fwu_pkg::*;

	logic [6:0]    run_year;

	logic          valid_s1;
	logic [31:0]   word_s1;
	logic [1:0]    fib_s1;
	logic          first_s1;

	fwu_state_t    state_q;
	fwu_trig_vec_t trig_q;

	fwu_state_t    state_nxt;
	fwu_trig_vec_t trig_nxt;
	logic          dec_valid;
	fwu_result_t   dec_res;

	logic          res_valid_s2;
	fwu_result_t   res_s2;

	logic          advance;

	fwu_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.run_year (run_year)
	);

	fwu_decode u_decode (
		.data_word      (word_s1),
		.fiber_index    (fib_s1),
		.first_of_fiber (first_s1),
		.run_year       (run_year),
		.state_cur      (state_q),
		.trig_cur       (trig_q),
		.state_nxt      (state_nxt),
		.trig_nxt       (trig_nxt),
		.res_valid      (dec_valid),
		.res            (dec_res)
	);

	// a word without a result never waits for the output side
	assign advance  = valid_s1 && (!dec_valid || !res_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			state_q      <= '0;
			trig_q       <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_nxt;
				trig_q  <= trig_nxt;
			end
			if (advance && dec_valid) begin
				res_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1  <= data_word;
			fib_s1   <= fiber_index;
			first_s1 <= first_of_fiber;
		end
		if (advance && dec_valid) begin
			res_s2 <= dec_res;
		end
	end

	assign out_valid       = res_valid_s2;
	assign result_kind     = res_s2.kind;
	assign fiber_out       = res_s2.fiber;
	assign tray_number     = res_s2.tray;
	assign channel_number  = res_s2.channel;
	assign tdc_time        = res_s2.tdc_time;
	assign raw_word        = res_s2.raw;
	assign channel_anomaly = res_s2.anomaly;

endmodule

`default_nettype wire

@@ rtl/core/fwu_cfg.sv @@
// ----------------------------------------------------------------------------
// fwu_cfg
// APB-style configuration register holding the run year.
// ----------------------------------------------------------------------------
`default_nettype none

module fwu_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fwu_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [6:0]                 run_year
);
	import fwu_pkg::*;

	logic [6:0] run_year_q;
	logic       wr_en;

	assign wr_en = psel && penable && pwrite && (paddr[2:2] == REG_RUN_YEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_year_q <= '0;
		end else if (wr_en) begin
			run_year_q <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:2] == REG_RUN_YEAR) begin
			prdata = {25'd0, run_year_q};
		end
	end

	assign pready   = 1'b1;
	assign run_year = run_year_q;

endmodule

`default_nettype wire

@@ rtl/core/fwu_decode.sv @@
// ----------------------------------------------------------------------------
// fwu_decode
// Word-type decode, state update and hit channel/time build for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module fwu_decode (
	input  logic                  [31:0] data_word,
	input  logic                  [1:0]  fiber_index,
	input  logic                         first_of_fiber,
	input  logic                  [6:0]  run_year,
	input  fwu_pkg::fwu_state_t          state_cur,
	input  fwu_pkg::fwu_trig_vec_t       trig_cur,
	output fwu_pkg::fwu_state_t          state_nxt,
	output fwu_pkg::fwu_trig_vec_t       trig_nxt,
	output logic                         res_valid,
	output fwu_pkg::fwu_result_t         res
);
	import fwu_pkg::*;

	logic        fib_ok;
	logic [3:0]  wtype;
	logic [3:0]  tdc;
	logic [1:0]  tdig;
	logic [2:0]  tdcchan;
	logic [20:0] fine_time;
	logic        special;
	logic [7:0]  chan_base;
	logic [7:0]  chan_norm;
	logic [7:0]  chan_remap;
	logic        anom;
	fwu_state_t  st;
	fwu_trig_vec_t trig;

	assign fib_ok    = 32'(fiber_index) < FIBER_COUNT;
	assign wtype     = data_word[31:28];
	assign tdc       = data_word[27:24];
	assign tdig      = tdc[3:2];
	assign tdcchan   = data_word[23:21];
	assign fine_time = {data_word[18:0], data_word[20:19]};

	// channel within tray: tdcchan + (tdc%4)*8 + tdig*24 + half*96
	assign chan_base  = {5'd0, tdcchan} + {3'd0, tdc[1:0], 3'd0};
	assign chan_remap = chan_base + CH_PER_TDIG;

	always_comb begin
		st   = state_cur;
		trig = trig_cur;
		if (first_of_fiber) begin
			st               = '0;
			trig[fiber_index] = 1'b0;
		end

		special = ((st.tray == TRAY_SPECIAL_A) || (st.tray == TRAY_SPECIAL_B) ||
			   (st.tray == TRAY_SPECIAL_C) || (st.tray == TRAY_SPECIAL_D)) &&
			  (run_year >= REMAP_YEAR);
		chan_norm = chan_base + 8'(tdig) * CH_PER_TDIG + (st.half_tray ? CH_PER_HALF : 8'd0);

		res_valid    = 1'b0;
		res          = '0;
		res.kind     = KIND_LEADING;
		res.fiber    = fiber_index;
		res.raw      = data_word;
		anom         = 1'b0;

		case (wtype)
			WT_HEADER, WT_SEPARATOR, WT_TRIG_FLAG: begin
			end
			WT_TRIG_TIME: begin
				if (!trig[fiber_index]) begin
					trig[fiber_index] = 1'b1;
					res_valid         = 1'b1;
					res.kind          = KIND_TRIGGER;
				end
			end
			WT_GEO: begin
				st.half_tray = data_word[0];
				st.tray      = data_word[7:1];
				st.geo_seen  = 1'b1;
			end
			default: begin
				if (st.geo_seen) begin
					res.tray = st.tray;
					if ((st.tray < TRAY_MIN) || (st.tray > TRAY_MAX)) begin
						res_valid = 1'b1;
						res.kind  = KIND_BAD_TRAY;
					end else if ((wtype == WT_LEADING) || (wtype == WT_TRAILING)) begin
						res_valid    = 1'b1;
						res.kind     = (wtype == WT_LEADING) ? KIND_LEADING : KIND_TRAILING;
						res.tdc_time = fine_time;
						if (special && !st.half_tray && (tdig == 2'd0)) begin
							res.channel = chan_remap;
						end else if (special &&
							     ((!st.half_tray && (tdig == TDIG_LOWER_ANOM)) ||
							      (st.half_tray && (tdig == TDIG_UPPER_ANOM)))) begin
							anom = 1'b1;
						end else begin
							res.channel = chan_norm;
						end
						res.anomaly = anom;
					end
				end
			end
		endcase

		// words from a fibre beyond the configured count leave everything alone
		if (!fib_ok) begin
			st        = state_cur;
			trig      = trig_cur;
			res_valid = 1'b0;
		end
	end

	assign state_nxt = st;
	assign trig_nxt  = trig;

endmodule

`default_nettype wire

@@ rtl/core/fwu_checker.sv @@
// ----------------------------------------------------------------------------
// fwu_checker
// Port-level checks on the unpacker's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fwu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [6:0]  tray_number,
	input logic [7:0]  channel_number,
	input logic [20:0] tdc_time,
	input logic [31:0] raw_word,
	input logic        channel_anomaly
);
	import fwu_pkg::*;

	// a stalled result request holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(raw_word) &&
		$stable(result_kind) && $stable(channel_number))
		else $error("result changed while stalled");

	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_TRIGGER) |->
		(tray_number == 7'd0) && (channel_number == 8'd0) && (tdc_time == 21'd0) &&
		(raw_word[31:28] == WT_TRIG_TIME))
		else $error("malformed trigger time result");

	a_anom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && channel_anomaly |-> (channel_number == 8'd0) &&
		((result_kind == KIND_LEADING) || (result_kind == KIND_TRAILING)))
		else $error("anomaly mark on a non-hit or with a channel");

	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((result_kind == KIND_LEADING) || (result_kind == KIND_TRAILING)) |->
		(channel_number <= CH_MAX) && (tray_number >= TRAY_MIN) &&
		(tray_number <= TRAY_MAX) && (tdc_time[1:0] == raw_word[20:19]))
		else $error("hit out of range");

endmodule

bind tof_fiber_word_unpacker_top fwu_checker u_fwu_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.result_kind     (result_kind),
	.tray_number     (tray_number),
	.channel_number  (channel_number),
	.tdc_time        (tdc_time),
	.raw_word        (raw_word),
	.channel_anomaly (channel_anomaly)
);

`default_nettype wire

@@ tb/sv/tof_fiber_word_unpacker_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tof_fiber_word_unpacker_top_tb
// Self-checking bench for the fibre word unpacker: the words of random fibre
// blocks go in over valid/ready, and a local decoder predicts each hit,
// trigger time and bad-tray error. run_year is set over APB between phases.
// ----------------------------------------------------------------------------

module tof_fiber_word_unpacker_top_tb;
	import fwu_pkg::*;

	localparam int HOLD_CYCLES  = 400;
	localparam int LATENCY_WAIT = 4;
	localparam int PHASE_WORDS  = 350;
	localparam logic [0:0] REG_UNMAPPED = ~REG_RUN_YEAR;
	// word types with no meaning of their own; they give a result only as a bad-tray error
	localparam logic [3:0] WT_UNUSED [9] = '{4'h0, 4'h1, 4'h3, 4'h6, 4'h7, 4'h8, 4'h9,
		4'hB, 4'hF};

	// Decodes words as the block should and keeps the results still owed.
	class fwu_result_scoreboard;
		fwu_result_t            owed_results[$];
		logic [6:0]             run_year;
		logic                   geo_seen;
		logic                   half_tray;
		logic [6:0]             tray_reg;
		logic [FIBER_COUNT-1:0] trig_taken;
		int                     errors;
		int                     checked;
		int                     anomalies;
		int                     kind_count[4];

		function new();
			run_year   = '0;
			geo_seen   = 1'b0;
			half_tray  = 1'b0;
			tray_reg   = '0;
			trig_taken = '0;
			errors     = 0;
			checked    = 0;
			anomalies  = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void owe(fwu_result_t r);
			owed_results.insert(owed_results.size(), r);
		endfunction

		function void unpack_word(logic [31:0] w, logic [1:0] fib, logic first);
			logic [3:0]  wtype;
			logic [3:0]  tdc;
			logic [1:0]  tdig;
			logic [2:0]  tdcchan;
			logic [7:0]  chan;
			logic [20:0] fine_time;
			logic        anom;
			logic        special;
			fwu_result_t r;

			if (int'(fib) >= FIBER_COUNT)
				return;
			if (first) begin
				geo_seen        = 1'b0;
				half_tray       = 1'b0;
				tray_reg        = '0;
				trig_taken[fib] = 1'b0;
			end
			wtype = w[31:28];
			if (wtype == WT_HEADER || wtype == WT_SEPARATOR || wtype == WT_TRIG_FLAG)
				return;
			r       = '0;
			r.fiber = fib;
			r.raw   = w;
			if (wtype == WT_TRIG_TIME) begin
				if (trig_taken[fib])
					return;
				trig_taken[fib] = 1'b1;
				r.kind = KIND_TRIGGER;
				owe(r);
				return;
			end
			if (wtype == WT_GEO) begin
				half_tray = w[0];
				tray_reg  = w[7:1];
				geo_seen  = 1'b1;
				return;
			end
			if (!geo_seen)
				return;
			r.tray = tray_reg;
			// any word of the remaining types under a bad tray is flagged, edge or not
			if (tray_reg < TRAY_MIN || tray_reg > TRAY_MAX) begin
				r.kind = KIND_BAD_TRAY;
				owe(r);
				return;
			end
			if (wtype != WT_LEADING && wtype != WT_TRAILING)
				return;

			tdc       = w[27:24];
			tdig      = tdc[3:2];
			tdcchan   = w[23:21];
			fine_time = {w[18:0], 2'b00} + 21'(w[20:19]);
			special   = (tray_reg == TRAY_SPECIAL_A || tray_reg == TRAY_SPECIAL_B ||
				tray_reg == TRAY_SPECIAL_C || tray_reg == TRAY_SPECIAL_D) &&
				run_year >= REMAP_YEAR;
			anom = 1'b0;
			if (special && !half_tray && tdig == 2'd0) begin
				chan = 8'(tdcchan) + 8'(tdc[1:0]) * 8'd8 + CH_PER_TDIG;
			end else if (special && ((!half_tray && tdig == TDIG_LOWER_ANOM) ||
				(half_tray && tdig == TDIG_UPPER_ANOM))) begin
				chan = '0;
				anom = 1'b1;
			end else begin
				chan = 8'(tdcchan) + 8'(tdc[1:0]) * 8'd8 + 8'(tdig) * CH_PER_TDIG +
					(half_tray ? CH_PER_HALF : 8'd0);
			end
			r.kind     = (wtype == WT_LEADING) ? KIND_LEADING : KIND_TRAILING;
			r.channel  = chan;
			r.tdc_time = fine_time;
			r.anomaly  = anom;
			owe(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
		endtask

		task check_result(fwu_result_t got);
			fwu_result_t want;

			if (owed_results.size() == 0) begin
				report($sformatf("result with nothing owed: kind %0d raw %08h",
					got.kind, got.raw));
				return;
			end
			want = owed_results.pop_front();
			checked++;
			compare_field("kind", 32'(got.kind), 32'(want.kind));
			compare_field("fiber", 32'(got.fiber), 32'(want.fiber));
			compare_field("tray", 32'(got.tray), 32'(want.tray));
			compare_field("channel", 32'(got.channel), 32'(want.channel));
			compare_field("tdc_time", 32'(got.tdc_time), 32'(want.tdc_time));
			compare_field("raw_word", got.raw, want.raw);
			compare_field("anomaly", 32'(got.anomaly), 32'(want.anomaly));
			kind_count[int'(want.kind)]++;
			if (want.anomaly)
				anomalies++;
		endtask
	endclass

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               psel           = 1'b0;
	logic               penable        = 1'b0;
	logic               pwrite         = 1'b0;
	logic [PADDR_W-1:0] paddr          = '0;
	logic [31:0]        pwdata         = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic [31:0]        data_word      = '0;
	logic [1:0]         fiber_index    = '0;
	logic               first_of_fiber = 1'b0;
	logic               out_valid;
	logic               out_ready      = 1'b1;
	logic [1:0]         result_kind;
	logic [1:0]         fiber_out;
	logic [6:0]         tray_number;
	logic [7:0]         channel_number;
	logic [20:0]        tdc_time;
	logic [31:0]        raw_word;
	logic               channel_anomaly;

	fwu_result_scoreboard sb;
	int    words_sent = 0;
	int    stall_left = 0;
	bit    idle_on    = 1'b1;
	bit    hold_req   = 1'b0;
	string years_log  = "";

	tof_fiber_word_unpacker_top u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin : watch
		fwu_result_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.unpack_word(data_word, fiber_index, first_of_fiber);
			if (out_valid && out_ready) begin
				got.kind     = fwu_kind_t'(result_kind);
				got.fiber    = fiber_out;
				got.tray     = tray_number;
				got.channel  = channel_number;
				got.tdc_time = tdc_time;
				got.raw      = raw_word;
				got.anomaly  = channel_anomaly;
				sb.check_result(got);
			end
		end
	end

	// result side: random stall bursts, plus one long hold to back the block up
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 18);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(logic [PADDR_W-1:0] addr, logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			sb.report($sformatf("run_year read back %0h, want %0h", prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_run_year(logic [6:0] year);
		apb_write({REG_RUN_YEAR, 2'b00}, {25'($urandom), year});
		sb.run_year = year;
		apb_read_check({REG_RUN_YEAR, 2'b00}, {25'd0, year});
		years_log = {years_log, $sformatf(" %0d", year)};
	endtask

	task automatic offer_word(logic [31:0] w, logic [1:0] fib, logic first);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		data_word      <= w;
		fiber_index    <= fib;
		first_of_fiber <= first;
		do @(posedge clk); while (!(in_valid && in_ready));
		words_sent++;
	endtask

	// wait for every owed result, then let any resultless words clear the pipe
	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] with_type(logic [3:0] wtype);
		return {wtype, 28'($urandom)};
	endfunction

	function automatic logic [31:0] geo_word(logic [6:0] tray, logic half);
		return {WT_GEO, 20'($urandom), tray, half};
	endfunction

	function automatic logic [31:0] edge_word(logic [3:0] wtype, logic [3:0] tdc,
		logic [2:0] tdcchan, logic [20:0] t);
		return {wtype, tdc, tdcchan, t};
	endfunction

	function automatic logic [6:0] pick_tray();
		case ($urandom_range(0, 15))
			0:       return 7'd0;
			1:       return 7'($urandom_range(int'(TRAY_MAX) + 1, 127));
			2:       return TRAY_SPECIAL_A;
			3:       return TRAY_SPECIAL_B;
			4:       return TRAY_SPECIAL_C;
			5:       return TRAY_SPECIAL_D;
			6:       return TRAY_MIN;
			7:       return TRAY_MAX;
			default: return 7'($urandom_range(int'(TRAY_MIN), int'(TRAY_MAX)));
		endcase
	endfunction

	task automatic directed_words();
		// edge before any geography, then the skipped types
		offer_word(edge_word(WT_LEADING, 4'd0, 3'd0, 21'd0), 2'd0, 1'b1);
		offer_word(with_type(WT_HEADER), 2'd0, 1'b0);
		offer_word(with_type(WT_SEPARATOR), 2'd0, 1'b0);
		offer_word(with_type(WT_TRIG_FLAG), 2'd0, 1'b0);
		// first trigger time reported, the repeat dropped
		offer_word(with_type(WT_TRIG_TIME), 2'd0, 1'b0);
		offer_word(with_type(WT_TRIG_TIME), 2'd0, 1'b0);
		// bad trays, edge and non-edge words
		offer_word(geo_word(7'd0, 1'b0), 2'd1, 1'b0);
		offer_word(with_type(WT_LEADING), 2'd1, 1'b0);
		offer_word(with_type(WT_UNUSED[4]), 2'd1, 1'b0);
		offer_word(geo_word(7'h7F, 1'b1), 2'd2, 1'b0);
		offer_word(with_type(WT_TRAILING), 2'd2, 1'b0);
		// special tray, lower half: remap, anomaly, normal
		offer_word(geo_word(TRAY_SPECIAL_A, 1'b0), 2'd0, 1'b0);
		offer_word(edge_word(WT_LEADING, 4'd3, 3'd5, 21'h0ABCDE), 2'd0, 1'b0);
		offer_word(edge_word(WT_TRAILING, 4'd6, 3'd1, 21'h155555), 2'd0, 1'b0);
		offer_word(edge_word(WT_LEADING, 4'd9, 3'd2, 21'h0AAAAA), 2'd0, 1'b0);
		// special tray, upper half: tdig 3 anomaly
		offer_word(geo_word(TRAY_SPECIAL_D, 1'b1), 2'd1, 1'b0);
		offer_word(edge_word(WT_LEADING, 4'd15, 3'd7, 21'h1FFFFF), 2'd1, 1'b0);
		offer_word(edge_word(WT_TRAILING, 4'd8, 3'd2, 21'h000001), 2'd1, 1'b0);
		// highest channel and time, then the lowest
		offer_word(geo_word(TRAY_MAX, 1'b1), 2'd2, 1'b0);
		offer_word(edge_word(WT_LEADING, 4'd15, 3'd7, 21'h1FFFFF), 2'd2, 1'b0);
		offer_word(geo_word(TRAY_MIN, 1'b0), 2'd3, 1'b0);
		offer_word(edge_word(WT_TRAILING, 4'd0, 3'd0, 21'd0), 2'd3, 1'b0);
		offer_word(with_type(WT_UNUSED[8]), 2'd3, 1'b0);
		offer_word(with_type(WT_UNUSED[0]), 2'd3, 1'b0);
		// new block on fibre 3 clears the geography
		offer_word(with_type(WT_TRIG_TIME), 2'd3, 1'b1);
		offer_word(with_type(WT_LEADING), 2'd3, 1'b0);
	endtask

	task automatic send_block();
		logic [1:0] fib;
		int         n;
		fib = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 7) == 0)
			offer_word($urandom, fib, 1'b1);
		else
			offer_word(with_type(WT_HEADER), fib, 1'b1);
		if ($urandom_range(0, 3) != 0)
			offer_word(with_type(WT_TRIG_TIME), fib, 1'b0);
		if ($urandom_range(0, 9) != 0)
			offer_word(geo_word(pick_tray(), 1'($urandom)), fib, 1'b0);
		n = $urandom_range(1, 12);
		repeat (n) begin
			case ($urandom_range(0, 19))
				0: offer_word(with_type(WT_TRIG_TIME), fib, 1'b0);
				1: offer_word(with_type(WT_TRIG_FLAG), fib, 1'b0);
				2: offer_word(with_type(WT_SEPARATOR), fib, 1'b0);
				3: offer_word(with_type(WT_UNUSED[$urandom_range(0, 8)]), fib, 1'b0);
				4: offer_word(geo_word(pick_tray(), 1'($urandom)), fib, 1'b0);
				5: offer_word(with_type(WT_LEADING), 2'($urandom), 1'b0);
				6: offer_word($urandom, 2'($urandom), 1'($urandom_range(0, 3) == 0));
				default: offer_word(with_type($urandom_range(0, 1) ? WT_TRAILING : WT_LEADING),
					fib, 1'b0);
			endcase
		end
	endtask

	initial begin
		int         target;
		logic [6:0] year;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_read_check({REG_RUN_YEAR, 2'b00}, 32'd0);
		set_run_year(REMAP_YEAR);
		// a write to an unmapped address must leave run_year alone
		apb_write({REG_UNMAPPED, 2'b00}, $urandom);
		apb_read_check({REG_RUN_YEAR, 2'b00}, {25'd0, REMAP_YEAR});
		directed_words();
		drain();

		target = words_sent;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0:       year = 7'd0;
				1:       year = 7'h7F;
				2:       year = REMAP_YEAR - 7'd1;
				3:       year = 7'($urandom_range(0, 127));
				default: year = REMAP_YEAR;
			endcase
			set_run_year(year);
			if (p == 0)
				hold_req = 1'b1;
			if (p == 4)
				idle_on = 1'b0;
			target += PHASE_WORDS;
			while (words_sent < target)
				send_block();
			drain();
		end

		repeat (2 * LATENCY_WAIT) @(posedge clk);
		if (sb.pending() > 0)
			sb.report($sformatf("%0d owed results never came out", sb.pending()));
		$display("Sent %0d fibre words under run_year%s; %0d results checked.",
			words_sent, years_log, sb.checked);
		$display("Leading %0d, trailing %0d, trigger %0d, bad tray %0d, anomalies %0d.",
			sb.kind_count[KIND_LEADING], sb.kind_count[KIND_TRAILING],
			sb.kind_count[KIND_TRIGGER], sb.kind_count[KIND_BAD_TRAY], sb.anomalies);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
